// ===== rtl/spmq_pkg.sv =====
// shared constants and types for the strict priority message queue
package spmq_pkg;

  localparam int NUM_LEVELS_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF  = 64;
  localparam int HANDLE_WIDTH_DEF = 32;

  // fixed field widths on the channels
  localparam int LEVEL_BITS  = 4;
  localparam int HANDLE_BITS = 32;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_kind_t;

  // outcome of one request, carried from the decision to the result stage
  typedef struct packed {
    logic                  pop_valid;
    logic [LEVEL_BITS-1:0] level;
    logic                  push_dropped;
  } spmq_meta_t;

endpackage

// ===== rtl/spmq_if.sv =====
// request and response channel interfaces
interface spmq_req_if import spmq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic                   has_level;
  logic [LEVEL_BITS-1:0]  level_in;
  logic [HANDLE_BITS-1:0] handle_in;

  modport source (output valid, req_type, has_level, level_in, handle_in, input ready);
  modport sink   (input valid, req_type, has_level, level_in, handle_in, output ready);
endinterface

interface spmq_rsp_if import spmq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   pop_valid;
  logic [HANDLE_BITS-1:0] handle_out;
  logic [LEVEL_BITS-1:0]  level_out;
  logic                   push_dropped;

  modport source (output valid, pop_valid, handle_out, level_out, push_dropped, input ready);
  modport sink   (input valid, pop_valid, handle_out, level_out, push_dropped, output ready);
endinterface

// ===== rtl/spmq_ctrl.sv =====
// per-level pointers and counts, level clamp and priority select
module spmq_ctrl import spmq_pkg::*; #(
  parameter int NUM_LEVELS   = NUM_LEVELS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF,
  localparam int LW = $clog2(NUM_LEVELS),
  localparam int PW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic                    req_type,
  input  logic                    has_level,
  input  logic [LEVEL_BITS-1:0]   level_in,
  input  logic [HANDLE_BITS-1:0]  handle_in,
  output spmq_meta_t              meta,
  output logic                    mem_wr,
  output logic                    mem_rd,
  output logic [LW+PW-1:0]        mem_addr,
  output logic [HANDLE_WIDTH-1:0] mem_wdata
);

  localparam logic [LEVEL_BITS-1:0] LOWEST = LEVEL_BITS'(NUM_LEVELS - 1);

  logic [PW-1:0] head  [NUM_LEVELS];
  logic [PW-1:0] tail  [NUM_LEVELS];
  logic [CW-1:0] count [NUM_LEVELS];

  logic          is_pop;
  logic          pop_any;
  logic          full;
  logic          do_push;
  logic          do_pop;
  logic [LW-1:0] push_lvl;
  logic [LW-1:0] pop_lvl;
  logic [LW-1:0] sel_lvl;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    is_pop   = (req_type == REQ_POP);
    // no level, or lowest and beyond, goes to the lowest level
    push_lvl = (has_level && (level_in < LOWEST)) ? level_in[LW-1:0] : LW'(NUM_LEVELS - 1);
    pop_lvl  = '0;
    pop_any  = 1'b0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        pop_lvl = LW'(i);
        pop_any = 1'b1;
      end
    end
    sel_lvl  = is_pop ? pop_lvl : push_lvl;
    full     = (count[push_lvl] == CW'(QUEUE_DEPTH));
    do_push  = accept && !is_pop && !full;
    do_pop   = accept && is_pop && pop_any;

    mem_wr    = do_push;
    mem_rd    = do_pop;
    mem_addr  = {sel_lvl, (is_pop ? head[sel_lvl] : tail[sel_lvl])};
    mem_wdata = HANDLE_WIDTH'(handle_in);

    meta.pop_valid    = is_pop && pop_any;
    meta.level        = (is_pop && pop_any) ? LEVEL_BITS'(pop_lvl) : '0;
    meta.push_dropped = !is_pop && full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (do_push) begin
        tail[push_lvl]  <= advance(tail[push_lvl]);
        count[push_lvl] <= count[push_lvl] + 1'b1;
      end
      if (do_pop) begin
        head[pop_lvl]  <= advance(head[pop_lvl]);
        count[pop_lvl] <= count[pop_lvl] - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/spmq_store.sv =====
// handle memory, one write or one registered read per cycle
module spmq_store import spmq_pkg::*; #(
  parameter int NUM_LEVELS   = NUM_LEVELS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF,
  localparam int AW = $clog2(NUM_LEVELS) + $clog2(QUEUE_DEPTH)
) (
  input  logic                    clk,
  input  logic                    wr,
  input  logic                    rd,
  input  logic [AW-1:0]           addr,
  input  logic [HANDLE_WIDTH-1:0] wdata,
  output logic [HANDLE_WIDTH-1:0] rdata
);

  localparam int ENTRIES = 1 << AW;

  logic [HANDLE_WIDTH-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[addr] <= wdata;
    end
    if (rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/spmq_resp.sv =====
// decision stage and output register of the response channel
module spmq_resp import spmq_pkg::*; #(
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  spmq_meta_t              meta,
  input  logic [HANDLE_WIDTH-1:0] rdata,
  output logic                    in_ready,
  spmq_rsp_if.source              rsp
);

  logic       s1_valid;
  spmq_meta_t s1_meta;
  logic       s1_move;

  assign s1_move  = s1_valid && (!rsp.valid || rsp.ready);
  assign in_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta;
    end
    if (s1_move) begin
      rsp.pop_valid    <= s1_meta.pop_valid;
      rsp.level_out    <= s1_meta.level;
      rsp.push_dropped <= s1_meta.push_dropped;
      rsp.handle_out   <= s1_meta.pop_valid ? HANDLE_BITS'(rdata) : '0;
    end
  end

endmodule

// ===== rtl/strict_priority_message_queue.sv =====
// top level of the strict priority message queue
//
// usage
//   req channel: one item per push or pop; req_type selects push or pop,
//     a push stores handle_in in the queue of its level (level_in when
//     has_level is set and it is above the lowest level, else the lowest)
//   rsp channel: exactly one item per request, in request order; a pop
//     gives the head of the highest-priority non-empty queue with its
//     level, or pop_valid low when all queues are empty; a push into a
//     full queue is discarded and reported by push_dropped
// timing
//   one request per cycle sustained while rsp.ready is high; a response
//   passes the memory read register, then the output register
//   pointer and count updates happen in the cycle the request is taken,
//   so a pop right after a push already sees it
// reset
//   synchronous rst empties every queue and clears both pipeline stages;
//   stored handles are not cleared, the counts keep them unreachable
// back-pressure
//   when rsp.ready stays low the output register holds, one more result
//   waits in the decision stage, then req.ready drops; nothing is lost
module strict_priority_message_queue import spmq_pkg::*; #(
  parameter int NUM_LEVELS   = NUM_LEVELS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  spmq_req_if.sink   req,
  spmq_rsp_if.source rsp
);

  localparam int AW = $clog2(NUM_LEVELS) + $clog2(QUEUE_DEPTH);

  logic                    accept;
  logic                    in_ready;
  spmq_meta_t              meta;
  logic                    mem_wr;
  logic                    mem_rd;
  logic [AW-1:0]           mem_addr;
  logic [HANDLE_WIDTH-1:0] mem_wdata;
  logic [HANDLE_WIDTH-1:0] mem_rdata;

  // request taken on valid and ready together
  assign req.ready = in_ready;
  assign accept    = req.valid && in_ready;

  // queue bookkeeping and priority pick
  spmq_ctrl #(
    .NUM_LEVELS  (NUM_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req_type (req.req_type),
    .has_level(req.has_level),
    .level_in (req.level_in),
    .handle_in(req.handle_in),
    .meta     (meta),
    .mem_wr   (mem_wr),
    .mem_rd   (mem_rd),
    .mem_addr (mem_addr),
    .mem_wdata(mem_wdata)
  );

  // shared handle storage, all levels side by side
  spmq_store #(
    .NUM_LEVELS  (NUM_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) u_store (
    .clk  (clk),
    .wr   (mem_wr),
    .rd   (mem_rd),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // response pipeline with skid into the output register
  spmq_resp #(
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) u_resp (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .meta    (meta),
    .rdata   (mem_rdata),
    .in_ready(in_ready),
    .rsp     (rsp)
  );

endmodule

// ===== rtl/spmq_checker.sv =====
// port-level checks on the strict priority message queue
module spmq_checker import spmq_pkg::*; #(
  parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic                   pop_valid,
  input logic [HANDLE_BITS-1:0] handle_out,
  input logic [LEVEL_BITS-1:0]  level_out,
  input logic                   push_dropped
);

  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("response valid after reset");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !pop_valid) |-> (handle_out == '0 && level_out == '0))
    else $error("non-zero payload without a popped message");

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(pop_valid && push_dropped))
    else $error("pop and drop flagged together");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && pop_valid) |-> (level_out <= LEVEL_BITS'(NUM_LEVELS - 1)))
    else $error("popped level out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(handle_out)))
    else $error("stalled response changed");

endmodule

bind strict_priority_message_queue spmq_checker #(
  .NUM_LEVELS(NUM_LEVELS)
) u_spmq_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .pop_valid   (rsp.pop_valid),
  .handle_out  (rsp.handle_out),
  .level_out   (rsp.level_out),
  .push_dropped(rsp.push_dropped)
);

// ===== dv/spmq_checker.sv =====
// response checker for the strict priority message queue: predicts and compares every item
`timescale 1ns / 100ps

module spmq_scoreboard import spmq_pkg::*; #(
  parameter int NUM_LEVELS   = NUM_LEVELS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  spmq_req_if  req,
  spmq_rsp_if  rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic                   pop_valid;
    logic [HANDLE_BITS-1:0] handle;
    logic [LEVEL_BITS-1:0]  level;
    logic                   push_dropped;
  } queue_result_t;

  // handles are kept to their low HANDLE_WIDTH bits
  localparam logic [HANDLE_BITS-1:0] HANDLE_KEEP = (HANDLE_WIDTH >= HANDLE_BITS) ? '1 :
    ({HANDLE_BITS{1'b1}} >> (HANDLE_BITS - HANDLE_WIDTH));

  logic [HANDLE_BITS-1:0] slot [NUM_LEVELS][QUEUE_DEPTH];
  int unsigned            rd_pos [NUM_LEVELS];
  int unsigned            wr_pos [NUM_LEVELS];
  int unsigned            held [NUM_LEVELS];
  queue_result_t          awaited [$];
  int                     mismatches = 0;

  assign fail_count = mismatches;

  // applies one request to the shadow queues and gives the response it should produce
  function automatic queue_result_t serve_request(logic kind, logic has, logic [LEVEL_BITS-1:0] lvl,
                                                  logic [HANDLE_BITS-1:0] handle);
    queue_result_t res;
    int unsigned   target;
    res = '0;
    if (kind == REQ_PUSH) begin
      target = NUM_LEVELS - 1;
      if (has && lvl < NUM_LEVELS - 1) target = lvl;
      if (held[target] >= QUEUE_DEPTH) begin
        res.push_dropped = 1'b1;
      end else begin
        slot[target][wr_pos[target]] = handle & HANDLE_KEEP;
        wr_pos[target] = (wr_pos[target] + 1) % QUEUE_DEPTH;
        held[target]++;
      end
    end else begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        if (held[i] != 0) begin
          res.pop_valid = 1'b1;
          res.handle    = slot[i][rd_pos[i]];
          res.level     = LEVEL_BITS'(i);
          rd_pos[i]     = (rd_pos[i] + 1) % QUEUE_DEPTH;
          held[i]--;
          break;
        end
      end
    end
    return res;
  endfunction

  function automatic int field_differs(string field, logic [HANDLE_BITS-1:0] want,
                                       logic [HANDLE_BITS-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        rd_pos[i] = 0;
        wr_pos[i] = 0;
        held[i]   = 0;
      end
      awaited.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited.size() == 0) begin
          $error("response item with no request outstanding");
          mismatches++;
        end else begin
          want = awaited.pop_front();
          mismatches += field_differs("pop_valid", want.pop_valid, rsp.pop_valid);
          mismatches += field_differs("handle_out", want.handle, rsp.handle_out);
          mismatches += field_differs("level_out", want.level, rsp.level_out);
          mismatches += field_differs("push_dropped", want.push_dropped, rsp.push_dropped);
        end
      end
      if (req.valid && req.ready)
        awaited = {awaited,
                   serve_request(req.req_type, req.has_level, req.level_in, req.handle_in)};
    end
    pending <= awaited.size();
  end

endmodule

// ===== dv/tb_strict_priority_message_queue.sv =====
// testbench top for the strict priority message queue: stimulus, stalls, watchdog and verdict
`timescale 1ns / 100ps

module tb_strict_priority_message_queue;
  import spmq_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int ITEM_GOAL  = 550;
  // cycles with no item moving on either channel before the run is abandoned
  localparam int IDLE_LIMIT = 2000;

  // kinds of traffic segment in the random part
  typedef enum int {SEG_MIXED, SEG_FILL, SEG_DRAIN} traffic_t;
  // response-side ready patterns
  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_HOLD} rx_pattern_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spmq_req_if req_ch ();
  spmq_rsp_if rsp_ch ();

  int fail_count;
  int pending;
  int burst_left = 0;
  int sent       = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  rx_pattern_t rx_pattern = RX_OPEN;

  always #(CLK_PERIOD / 2) clk = ~clk;

  strict_priority_message_queue #(
    .NUM_LEVELS   (NUM_LEVELS_DEF),
    .QUEUE_DEPTH  (QUEUE_DEPTH_DEF),
    .HANDLE_WIDTH (HANDLE_WIDTH_DEF)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  spmq_scoreboard #(
    .NUM_LEVELS   (NUM_LEVELS_DEF),
    .QUEUE_DEPTH  (QUEUE_DEPTH_DEF),
    .HANDLE_WIDTH (HANDLE_WIDTH_DEF)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // known values on every input from time zero
  initial begin
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_PUSH;
    req_ch.has_level = 1'b0;
    req_ch.level_in  = '0;
    req_ch.handle_in = '0;
    rsp_ch.ready     = 1'b1;
  end

  // response side: phases of random length, each with its own ready pattern,
  // so stalls land on every stage of the pipeline and some stretches never stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      stall_left = $urandom_range(4, 50);
    end
    stall_left--;
    case (rx_pattern)
      RX_OPEN:   rsp_ch.ready <= 1'b1;
      RX_RANDOM: rsp_ch.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      default:   rsp_ch.ready <= 1'b0;
    endcase
  end

  // watchdog: any item moving on either side counts as progress
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_strict_priority_message_queue: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request item; the sender runs in bursts with random gaps between them,
  // and a gap of zero joins two bursts into one unbroken stretch
  task automatic send_req(input req_kind_t kind, input logic has, input logic [LEVEL_BITS-1:0] lvl,
                          input logic [HANDLE_BITS-1:0] handle);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.has_level <= has;
    req_ch.level_in  <= lvl;
    req_ch.handle_in <= handle;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  // pop fields other than req_type are ignored by the block, so they carry noise
  task automatic pop_item();
    send_req(REQ_POP, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom);
  endtask

  // random push of any shape, clamped levels and missing priorities included
  task automatic push_any();
    send_req(REQ_PUSH, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom);
  endtask

  // push aimed at one queue; the lowest one is reached by every clamped form
  task automatic push_to_level(input int unsigned target);
    logic has;
    has = (target == NUM_LEVELS_DEF - 1) ? 1'($urandom_range(0, 1)) : 1'b1;
    if (!has)
      send_req(REQ_PUSH, 1'b0, 4'($urandom_range(0, 15)), $urandom);
    else if (target == NUM_LEVELS_DEF - 1)
      send_req(REQ_PUSH, 1'b1, 4'($urandom_range(target, 15)), $urandom);
    else
      send_req(REQ_PUSH, 1'b1, 4'(target), $urandom);
  endtask

  // sender holds off until every outstanding response has come back
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    traffic_t    seg;
    int unsigned target;
    bit          first_seg;
    bit          paused;
    first_seg = 1'b1;
    paused    = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: pops on an empty block, with the ignored fields at both extremes
    send_req(REQ_POP, 1'b0, 4'h0, 32'h0000_0000);
    send_req(REQ_POP, 1'b1, 4'hf, 32'hffff_ffff);
    // one push per level, plus every clamped form: no priority, lowest level,
    // beyond the lowest level and the largest level value
    send_req(REQ_PUSH, 1'b1, 4'd0, 32'hffff_ffff);
    send_req(REQ_PUSH, 1'b1, 4'd1, 32'h0000_0000);
    send_req(REQ_PUSH, 1'b1, 4'd2, 32'ha5a5_a5a5);
    send_req(REQ_PUSH, 1'b1, 4'd3, 32'h5a5a_5a5a);
    send_req(REQ_PUSH, 1'b1, 4'hf, $urandom);
    send_req(REQ_PUSH, 1'b0, 4'd0, $urandom);
    send_req(REQ_PUSH, 1'b0, 4'hf, $urandom);
    send_req(REQ_PUSH, 1'b1, 4'd4, $urandom);
    // second entry in the top queue checks fifo order within a level
    send_req(REQ_PUSH, 1'b1, 4'd0, 32'h0000_0001);
    // drain in priority order, then one pop more on the empty block
    repeat (10) pop_item();

    drain_responses();

    // random part: mixed traffic, fills that run one chosen queue into its full
    // state and beyond, and drains made of long runs of pops
    while (sent < ITEM_GOAL) begin
      if (first_seg) seg = SEG_FILL;
      else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: seg = SEG_MIXED;
          4, 5, 6:    seg = SEG_FILL;
          default:    seg = SEG_DRAIN;
        endcase
      end
      first_seg = 1'b0;
      case (seg)
        SEG_MIXED: begin
          repeat ($urandom_range(10, 40)) begin
            if ($urandom_range(0, 1)) push_any();
            else pop_item();
          end
        end
        SEG_FILL: begin
          target = $urandom_range(0, NUM_LEVELS_DEF - 1);
          repeat (QUEUE_DEPTH_DEF + $urandom_range(1, 3)) push_to_level(target);
        end
        default: begin
          repeat ($urandom_range(20, 140)) pop_item();
        end
      endcase
      // once in mid-run the sender waits for the pipeline to empty
      if (!paused && sent >= ITEM_GOAL / 2) begin
        paused = 1'b1;
        drain_responses();
      end
    end

    drain_responses();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("tb_strict_priority_message_queue: PASS");
    else
      $display("tb_strict_priority_message_queue: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/spmq_pkg.sv
rtl/spmq_if.sv
rtl/spmq_ctrl.sv
rtl/spmq_store.sv
rtl/spmq_resp.sv
rtl/strict_priority_message_queue.sv
rtl/spmq_checker.sv
dv/spmq_checker.sv
dv/tb_strict_priority_message_queue.sv
